### rtl/core/glpd_pkg.sv
package glpd_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_WALK_DATA,
        S_POP_RD,
        S_POP_OUT
    } glpd_state_t;

    typedef enum logic [2:0] {
        ST_PIXEL    = 3'd0,
        ST_TAKEN    = 3'd1,
        ST_NEED     = 3'd2,
        ST_CLEARED  = 3'd3,
        ST_END      = 3'd4,
        ST_TERM     = 3'd5,
        ST_BAD_CODE = 3'd6,
        ST_OVERFLOW = 3'd7
    } glpd_status_t;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_PULL = 1'b1;

    localparam logic [1:0] REG_ROOT   = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;
    localparam logic [1:0] REG_ILACE  = 2'd3;

    localparam logic [5:0]  WIN_BITS      = 6'd32;
    localparam logic [5:0]  OVF_LIMIT     = 6'd24;
    localparam logic [3:0]  ROOT_MIN      = 4'd2;
    localparam logic [3:0]  ROOT_MAX      = 4'd8;
    localparam logic [3:0]  ROOT_RESET    = 4'd8;

    function automatic logic [3:0] eff_root(input logic [3:0] r);
        logic [3:0] v;
        v = r;
        if (r < ROOT_MIN)
        begin
            v = ROOT_MIN;
        end
        if (r > ROOT_MAX)
        begin
            v = ROOT_MAX;
        end
        return v;
    endfunction

endpackage

### rtl/core/glpd_cmd_if.sv
interface glpd_cmd_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink (input valid, input operation, input data_byte, output ready);
endinterface

### rtl/core/glpd_rsp_if.sv
interface glpd_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  pixel;
    logic [15:0] column;
    logic [15:0] row;
    logic        line_end;

    modport source (output valid, output status, output pixel, output column, output row,
                    output line_end, input ready);
    modport sink (input valid, input status, input pixel, input column, input row,
                  input line_end, output ready);
endinterface

### rtl/core/gif_lzw_pixel_decoder.sv
// a push word or a pull that needs no table walk returns its result at the next edge
// a pull that pops a stacked pixel reads the stack, then shows the pixel; a pull that
// decodes a code walks the table, one read of the prefix/suffix tables per entry, then pops
// one word is in flight at a time; the next is taken once the result register is free
// rst_n is asynchronous active low: control state, window and position go to zero,
// config returns to its defaults; the table and stack memories are not cleared
module gif_lzw_pixel_decoder #(
    parameter int TABLE_BITS = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    glpd_cmd_if.sink          cmd,
    glpd_rsp_if.source        rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int TSIZE = 1 << TABLE_BITS;
    localparam int NW    = TABLE_BITS + 1;

    glpd_pkg::glpd_state_t state_reg, state_next;

    logic [3:0]  root_reg, root_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic        ilace_reg, ilace_next;

    logic [NW-1:0]  depth_reg, depth_next;
    logic [31:0]    win_reg, win_next;
    logic [5:0]     wbits_reg, wbits_next;
    logic [3:0]     cw_reg, cw_next;
    logic [NW-1:0]  ncode_reg, ncode_next;
    logic [7:0]     pfirst_reg, pfirst_next;
    logic [7:0]     sub_reg, sub_next;
    logic [15:0]    x_reg, x_next;
    logic [15:0]    y_reg, y_next;
    logic [2:0]     pass_reg, pass_next;
    logic           halted_reg, halted_next;
    logic [2:0]     hst_reg, hst_next;
    logic           ended_reg, ended_next;
    logic [TABLE_BITS-1:0] k_reg, k_next;
    logic [TABLE_BITS-1:0] c_reg, c_next;

    logic        ov_reg, ov_next;
    logic [2:0]  ost_reg, ost_next;
    logic [7:0]  opix_reg, opix_next;
    logic [15:0] ocol_reg, ocol_next;
    logic [15:0] orow_reg, orow_next;
    logic        olast_reg, olast_next;

    logic [TABLE_BITS-1:0] pfx_mem [TSIZE];
    logic [7:0]            sfx_mem [TSIZE];
    logic [7:0]            stk_mem [TSIZE];
    logic [TABLE_BITS-1:0] pfx_rdata_reg;
    logic [7:0]            sfx_rdata_reg;
    logic [7:0]            stk_rdata_reg;

    logic                  pfx_we, sfx_we, stk_we, tbl_re, stk_re;
    logic [TABLE_BITS-1:0] pfx_waddr, sfx_waddr, stk_waddr, tbl_raddr, stk_raddr;
    logic [TABLE_BITS-1:0] pfx_wdata;
    logic [7:0]            sfx_wdata, stk_wdata;

    logic        acc, cfg_wr, can_load;
    logic [3:0]  root_eff, new_root_eff;
    logic [12:0] clear13, code13, nc13, k13;
    logic [11:0] mask12, code12;
    logic [31:0] win_sh;
    logic [5:0]  shamt;
    logic        last;
    logic [16:0] y_inc;
    logic [15:0] y_adv;
    logic [2:0]  pass_adv;
    logic [2:0]  pass_bump;
    logic [3:0]  inc;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb
    begin
        case (paddr[3:2])
            glpd_pkg::REG_ROOT:   prdata = {28'd0, root_reg};
            glpd_pkg::REG_WIDTH:  prdata = {16'd0, width_reg};
            glpd_pkg::REG_HEIGHT: prdata = {16'd0, height_reg};
            glpd_pkg::REG_ILACE:  prdata = {31'd0, ilace_reg};
            default:              prdata = 32'd0;
        endcase
    end

    assign cmd.ready    = (state_reg == glpd_pkg::S_IDLE) && (!ov_reg || rsp.ready);
    assign acc          = cmd.valid && cmd.ready;
    assign can_load     = !ov_reg || rsp.ready;
    assign rsp.valid    = ov_reg;
    assign rsp.status   = ost_reg;
    assign rsp.pixel    = opix_reg;
    assign rsp.column   = ocol_reg;
    assign rsp.row      = orow_reg;
    assign rsp.line_end = olast_reg;

    assign root_eff     = glpd_pkg::eff_root(root_reg);
    assign new_root_eff = glpd_pkg::eff_root(pwdata[3:0]);
    assign clear13      = 13'd1 << root_eff;
    assign mask12       = 12'((13'd1 << cw_reg) - 13'd1);
    assign shamt        = glpd_pkg::WIN_BITS - wbits_reg;
    assign win_sh       = win_reg >> shamt;
    assign code12       = win_sh[11:0] & mask12;
    assign code13       = {1'b0, code12};
    assign nc13         = 13'(ncode_reg);
    assign k13          = 13'(k_reg);
    assign last         = (17'(x_reg) + 17'd1) >= 17'(width_reg);

    // row step for the line that ends with this pixel
    always_comb
    begin
        case (pass_reg)
            3'd0, 3'd1: inc = 4'd8;
            3'd2:       inc = 4'd4;
            3'd3:       inc = 4'd2;
            default:    inc = 4'd0;
        endcase
        y_inc     = 17'(y_reg) + 17'(inc);
        pass_bump = (pass_reg < 3'd4) ? pass_reg + 3'd1 : pass_reg;
        y_adv     = y_reg;
        pass_adv  = pass_reg;
        if (ilace_reg)
        begin
            y_adv = y_inc[15:0];
            if (y_inc >= 17'(height_reg))
            begin
                pass_adv = pass_bump;
                case (pass_bump)
                    3'd1:    y_adv = 16'd4;
                    3'd2:    y_adv = 16'd2;
                    3'd3:    y_adv = 16'd1;
                    default: y_adv = 16'd0;
                endcase
            end
        end
        else if (y_reg < height_reg)
        begin
            y_adv = y_reg + 16'd1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            glpd_pkg::S_IDLE:
            begin
                if (acc && cmd.operation == glpd_pkg::OP_PULL)
                begin
                    if (depth_reg != '0)
                    begin
                        state_next = glpd_pkg::S_POP_OUT;
                    end
                    else if (!halted_reg && !ended_reg && wbits_reg >= {2'b00, cw_reg}
                             && code13 != clear13 && code13 != clear13 + 13'd1
                             && !(code13 > clear13 + 13'd1 && code13 > nc13))
                    begin
                        state_next = glpd_pkg::S_WALK;
                    end
                end
            end
            glpd_pkg::S_WALK:
            begin
                if (k13 < clear13)
                begin
                    state_next = (depth_next != '0) ? glpd_pkg::S_POP_RD : glpd_pkg::S_IDLE;
                end
                else
                begin
                    state_next = glpd_pkg::S_WALK_DATA;
                end
            end
            glpd_pkg::S_WALK_DATA: state_next = glpd_pkg::S_WALK;
            glpd_pkg::S_POP_RD:    state_next = glpd_pkg::S_POP_OUT;
            glpd_pkg::S_POP_OUT:
            begin
                if (can_load)
                begin
                    state_next = glpd_pkg::S_IDLE;
                end
            end
            default: state_next = glpd_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        root_next   = root_reg;
        width_next  = width_reg;
        height_next = height_reg;
        ilace_next  = ilace_reg;
        depth_next  = depth_reg;
        win_next    = win_reg;
        wbits_next  = wbits_reg;
        cw_next     = cw_reg;
        ncode_next  = ncode_reg;
        pfirst_next = pfirst_reg;
        sub_next    = sub_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        pass_next   = pass_reg;
        halted_next = halted_reg;
        hst_next    = hst_reg;
        ended_next  = ended_reg;
        k_next      = k_reg;
        c_next      = c_reg;
        ov_next     = ov_reg && !rsp.ready;
        ost_next    = ost_reg;
        opix_next   = opix_reg;
        ocol_next   = ocol_reg;
        orow_next   = orow_reg;
        olast_next  = olast_reg;
        pfx_we      = 1'b0;
        pfx_waddr   = '0;
        pfx_wdata   = '0;
        sfx_we      = 1'b0;
        sfx_waddr   = '0;
        sfx_wdata   = '0;
        stk_we      = 1'b0;
        stk_waddr   = depth_reg[TABLE_BITS-1:0];
        stk_wdata   = '0;
        tbl_re      = 1'b0;
        tbl_raddr   = k_reg;
        stk_re      = 1'b0;
        stk_raddr   = '0;

        case (state_reg)
            glpd_pkg::S_IDLE:
            begin
                if (acc)
                begin
                    ov_next    = 1'b1;
                    opix_next  = '0;
                    ocol_next  = '0;
                    orow_next  = '0;
                    olast_next = 1'b0;
                    if (cmd.operation == glpd_pkg::OP_PUSH)
                    begin
                        ost_next = glpd_pkg::ST_TAKEN;
                        if (halted_reg)
                        begin
                            ost_next = hst_reg;
                        end
                        else if (sub_reg == 8'd0)
                        begin
                            if (cmd.data_byte == 8'd0)
                            begin
                                halted_next = 1'b1;
                                hst_next    = glpd_pkg::ST_TERM;
                                ost_next    = glpd_pkg::ST_TERM;
                            end
                            else
                            begin
                                sub_next = cmd.data_byte;
                            end
                        end
                        else
                        begin
                            sub_next = sub_reg - 8'd1;
                            if (!ended_reg)
                            begin
                                if (wbits_reg > glpd_pkg::OVF_LIMIT)
                                begin
                                    halted_next = 1'b1;
                                    hst_next    = glpd_pkg::ST_OVERFLOW;
                                    ost_next    = glpd_pkg::ST_OVERFLOW;
                                end
                                else
                                begin
                                    win_next   = (win_reg >> 8) | {cmd.data_byte, 24'd0};
                                    wbits_next = wbits_reg + 6'd8;
                                end
                            end
                        end
                    end
                    else if (depth_reg != '0)
                    begin
                        ov_next    = ov_reg && !rsp.ready;
                        stk_re     = 1'b1;
                        stk_raddr  = TABLE_BITS'(depth_reg - NW'(1));
                        depth_next = depth_reg - NW'(1);
                    end
                    else if (halted_reg)
                    begin
                        ost_next = hst_reg;
                    end
                    else if (ended_reg)
                    begin
                        ost_next = glpd_pkg::ST_END;
                    end
                    else if (wbits_reg < {2'b00, cw_reg})
                    begin
                        ost_next = glpd_pkg::ST_NEED;
                    end
                    else
                    begin
                        wbits_next = wbits_reg - {2'b00, cw_reg};
                        if (code13 == clear13)
                        begin
                            cw_next    = root_eff + 4'd1;
                            ncode_next = NW'(clear13 + 13'd1);
                            ost_next   = glpd_pkg::ST_CLEARED;
                        end
                        else if (code13 == clear13 + 13'd1)
                        begin
                            ended_next = 1'b1;
                            ost_next   = glpd_pkg::ST_END;
                        end
                        else if (code13 > clear13 + 13'd1 && code13 > nc13)
                        begin
                            halted_next = 1'b1;
                            hst_next    = glpd_pkg::ST_BAD_CODE;
                            ost_next    = glpd_pkg::ST_BAD_CODE;
                        end
                        else
                        begin
                            ov_next = ov_reg && !rsp.ready;
                            // code not yet in the table: its suffix is the last first pixel
                            if (code13 == nc13)
                            begin
                                sfx_we    = 1'b1;
                                sfx_waddr = code12[TABLE_BITS-1:0];
                                sfx_wdata = pfirst_reg;
                            end
                            k_next = code12[TABLE_BITS-1:0];
                            c_next = code12[TABLE_BITS-1:0];
                        end
                    end
                end
            end
            glpd_pkg::S_WALK:
            begin
                if (k13 < clear13)
                begin
                    if (13'(depth_reg) < 13'(TSIZE))
                    begin
                        stk_we     = 1'b1;
                        stk_wdata  = k_reg[7:0];
                        depth_next = depth_reg + NW'(1);
                    end
                    pfirst_next = k_reg[7:0];
                    if (nc13 < 13'(TSIZE))
                    begin
                        sfx_we    = 1'b1;
                        sfx_waddr = ncode_reg[TABLE_BITS-1:0];
                        sfx_wdata = k_reg[7:0];
                        if (nc13 + 13'd1 < 13'(TSIZE))
                        begin
                            pfx_we    = 1'b1;
                            pfx_waddr = TABLE_BITS'(ncode_reg + NW'(1));
                            pfx_wdata = c_reg;
                        end
                        ncode_next = ncode_reg + NW'(1);
                        if (cw_reg < 4'(TABLE_BITS) && nc13 + 13'd1 == (13'd1 << cw_reg))
                        begin
                            cw_next = cw_reg + 4'd1;
                        end
                    end
                    if (depth_next == '0)
                    begin
                        ov_next    = 1'b1;
                        ost_next   = glpd_pkg::ST_PIXEL;
                        opix_next  = '0;
                        ocol_next  = '0;
                        orow_next  = '0;
                        olast_next = 1'b0;
                    end
                end
                else
                begin
                    tbl_re = 1'b1;
                end
            end
            glpd_pkg::S_WALK_DATA:
            begin
                if (13'(depth_reg) < 13'(TSIZE))
                begin
                    stk_we     = 1'b1;
                    stk_wdata  = sfx_rdata_reg;
                    depth_next = depth_reg + NW'(1);
                end
                k_next = pfx_rdata_reg;
            end
            glpd_pkg::S_POP_RD:
            begin
                stk_re     = 1'b1;
                stk_raddr  = TABLE_BITS'(depth_reg - NW'(1));
                depth_next = depth_reg - NW'(1);
            end
            glpd_pkg::S_POP_OUT:
            begin
                if (can_load)
                begin
                    ov_next    = 1'b1;
                    ost_next   = glpd_pkg::ST_PIXEL;
                    opix_next  = stk_rdata_reg;
                    ocol_next  = x_reg;
                    orow_next  = y_reg;
                    olast_next = last;
                    if (last)
                    begin
                        x_next    = 16'd0;
                        y_next    = y_adv;
                        pass_next = pass_adv;
                    end
                    else
                    begin
                        x_next = x_reg + 16'd1;
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (cfg_wr)
        begin
            case (paddr[3:2])
                glpd_pkg::REG_ROOT:
                begin
                    root_next  = pwdata[3:0];
                    cw_next    = new_root_eff + 4'd1;
                    ncode_next = NW'((13'd1 << new_root_eff) + 13'd1);
                end
                glpd_pkg::REG_WIDTH:  width_next  = pwdata[15:0];
                glpd_pkg::REG_HEIGHT: height_next = pwdata[15:0];
                glpd_pkg::REG_ILACE:  ilace_next  = pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pfx_we)
        begin
            pfx_mem[pfx_waddr] <= pfx_wdata;
        end
        if (tbl_re)
        begin
            pfx_rdata_reg <= pfx_mem[tbl_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sfx_we)
        begin
            sfx_mem[sfx_waddr] <= sfx_wdata;
        end
        if (tbl_re)
        begin
            sfx_rdata_reg <= sfx_mem[tbl_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re)
        begin
            stk_rdata_reg <= stk_mem[stk_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= glpd_pkg::S_IDLE;
            root_reg   <= glpd_pkg::ROOT_RESET;
            width_reg  <= 16'd1;
            height_reg <= 16'd1;
            ilace_reg  <= 1'b0;
            depth_reg  <= '0;
            win_reg    <= '0;
            wbits_reg  <= '0;
            cw_reg     <= glpd_pkg::ROOT_RESET + 4'd1;
            ncode_reg  <= NW'((13'd1 << glpd_pkg::ROOT_RESET) + 13'd1);
            pfirst_reg <= '0;
            sub_reg    <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
            pass_reg   <= '0;
            halted_reg <= 1'b0;
            hst_reg    <= '0;
            ended_reg  <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            root_reg   <= root_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            ilace_reg  <= ilace_next;
            depth_reg  <= depth_next;
            win_reg    <= win_next;
            wbits_reg  <= wbits_next;
            cw_reg     <= cw_next;
            ncode_reg  <= ncode_next;
            pfirst_reg <= pfirst_next;
            sub_reg    <= sub_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            pass_reg   <= pass_next;
            halted_reg <= halted_next;
            hst_reg    <= hst_next;
            ended_reg  <= ended_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg     <= k_next;
        c_reg     <= c_next;
        ost_reg   <= ost_next;
        opix_reg  <= opix_next;
        ocol_reg  <= ocol_next;
        orow_reg  <= orow_next;
        olast_reg <= olast_next;
    end

`ifndef SYNTHESIS
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        13'(depth_reg) <= 13'(TSIZE))
        else $error("pixel stack depth past table size");

    a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wbits_reg <= glpd_pkg::WIN_BITS)
        else $error("bit window count past 32");

    a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != glpd_pkg::S_IDLE |-> !cmd.ready)
        else $error("word taken while decoder busy");

    a_pop_gives_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == glpd_pkg::S_POP_OUT && can_load)
        |=> (ov_reg && ost_reg == glpd_pkg::ST_PIXEL))
        else $error("popped pixel not presented");

    a_walk_from_decode: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == glpd_pkg::S_WALK_DATA |-> $past(state_reg) == glpd_pkg::S_WALK)
        else $error("table data step without read");
`endif

endmodule
